// ===== src/lms_pkg.sv =====
// Shared types and codes for the lock motor sequencer.
`timescale 1ns / 1ps

package lms_pkg;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DRIVE   = 2'd1,
        PH_SETTLE  = 2'd2,
        PH_REVERSE = 2'd3
    } phase_t;

    // Input word kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_OPEN  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    // Reply codes
    localparam logic [2:0] REPLY_NONE           = 3'd0;
    localparam logic [2:0] REPLY_OK             = 3'd1;
    localparam logic [2:0] REPLY_DOOR_OPEN      = 3'd2;
    localparam logic [2:0] REPLY_ALREADY_CLOSED = 3'd3;
    localparam logic [2:0] REPLY_ALREADY_OPEN   = 3'd4;

    // Configuration register indexes
    localparam int          CFG_INDEX_W           = 3;
    localparam int          CFG_DATA_W            = 12;
    localparam logic [2:0]  CFG_POLL_INTERVAL     = 3'd0;
    localparam logic [2:0]  CFG_CLOSE_SETTLE_TIME = 3'd1;
    localparam logic [2:0]  CFG_OPEN_SETTLE_TIME  = 3'd2;
    localparam logic [2:0]  CFG_DRIVE_TIMEOUT     = 3'd3;
    localparam logic [2:0]  CFG_REVERSE_PULSE     = 3'd4;

    // Configuration reset values
    localparam logic [9:0]  RST_POLL_INTERVAL     = 10'd100;
    localparam logic [11:0] RST_CLOSE_SETTLE_TIME = 12'd300;
    localparam logic [11:0] RST_OPEN_SETTLE_TIME  = 12'd400;
    localparam logic [11:0] RST_DRIVE_TIMEOUT     = 12'd3000;
    localparam logic [11:0] RST_REVERSE_PULSE     = 12'd100;

    // Configuration set handed to the control core
    typedef struct packed {
        logic [9:0]  poll_interval;
        logic [11:0] close_settle_time;
        logic [11:0] open_settle_time;
        logic [11:0] drive_timeout;
        logic [11:0] reverse_pulse_time;
    } cfg_t;

    // Input word
    typedef struct packed {
        logic [1:0] kind;
        logic       silent;
        logic       lock_is_open;
        logic       door_is_closed;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic       drive_open;
        logic       drive_close;
        logic [2:0] reply;
        logic       busy_res;
        logic [1:0] phase_now;
    } out_word_t;

endpackage

// ===== src/lms_core.sv =====
// Sequencer state registers and the single-pass next-state and result logic.
`timescale 1ns / 1ps

module lms_core import lms_pkg::*; #(
    parameter int TIME_BITS = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_word_t  in_word,
    input  cfg_t      cfg,
    output out_word_t result
);

    localparam int CW = (TIME_BITS > 12) ? TIME_BITS : 12;
    localparam int SW = ((TIME_BITS > 10) ? TIME_BITS : 10) + 1;
    localparam logic [CW-1:0] TMAX_C = CW'((1 << TIME_BITS) - 1);
    localparam logic [SW-1:0] TMAX_S = SW'((1 << TIME_BITS) - 1);
    localparam logic [TIME_BITS-1:0] TMAX_T = {TIME_BITS{1'b1}};

    phase_t               phase_reg, phase_next;
    logic                 closing_reg, closing_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [9:0]           poll_reg, poll_next;
    logic [TIME_BITS-1:0] timer_reg, timer_next;
    logic [2:0]           reply;

    // Clamped configuration times
    logic [CW-1:0]        settle_w, rev_w, tout_w;
    logic [TIME_BITS-1:0] settle_c, rev_c, tout_c;
    logic [9:0]           interval;
    logic [9:0]           poll_inc;
    logic [SW-1:0]        elapsed_sum;
    logic [TIME_BITS-1:0] elapsed_new;
    logic [TIME_BITS-1:0] timer_inc;
    logic                 sensed;

    always_comb begin
        settle_w = closing_reg ? CW'(cfg.close_settle_time) : CW'(cfg.open_settle_time);
        settle_c = TIME_BITS'((settle_w > TMAX_C) ? TMAX_C : settle_w);
        rev_w    = CW'(cfg.reverse_pulse_time);
        rev_c    = TIME_BITS'((rev_w > TMAX_C) ? TMAX_C : rev_w);
        tout_w   = (cfg.drive_timeout == 12'd0) ? CW'(1) : CW'(cfg.drive_timeout);
        tout_c   = TIME_BITS'((tout_w > TMAX_C) ? TMAX_C : tout_w);
        interval = (cfg.poll_interval == 10'd0) ? 10'd1 : cfg.poll_interval;
        poll_inc = poll_reg + 10'd1;
        elapsed_sum = SW'(elapsed_reg) + SW'(interval);
        elapsed_new = TIME_BITS'((elapsed_sum > TMAX_S) ? TMAX_S : elapsed_sum);
        timer_inc = (timer_reg < TMAX_T) ? timer_reg + TIME_BITS'(1) : timer_reg;
        sensed   = closing_reg ? ~in_word.lock_is_open : in_word.lock_is_open;
    end

    // Next state
    always_comb begin
        phase_next   = phase_reg;
        closing_next = closing_reg;
        elapsed_next = elapsed_reg;
        poll_next    = poll_reg;
        timer_next   = timer_reg;
        reply        = REPLY_NONE;
        if (in_word.kind == KIND_TICK) begin
            case (phase_reg)
                PH_DRIVE: begin
                    poll_next = poll_inc;
                    if (poll_inc >= interval) begin
                        poll_next    = 10'd0;
                        elapsed_next = elapsed_new;
                        if (sensed) begin
                            timer_next = '0;
                            if (settle_c != '0) begin
                                phase_next = PH_SETTLE;
                            end else if (rev_c != '0) begin
                                phase_next = PH_REVERSE;
                            end else begin
                                phase_next = PH_IDLE;
                            end
                        end else if (elapsed_new >= tout_c) begin
                            timer_next = '0;
                            phase_next = (rev_c != '0) ? PH_REVERSE : PH_IDLE;
                        end
                    end
                end
                PH_SETTLE: begin
                    timer_next = timer_inc;
                    if (timer_inc >= settle_c) begin
                        timer_next = '0;
                        phase_next = (rev_c != '0) ? PH_REVERSE : PH_IDLE;
                    end
                end
                PH_REVERSE: begin
                    timer_next = timer_inc;
                    if (timer_inc >= rev_c) begin
                        phase_next = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end else if (phase_reg == PH_IDLE && in_word.kind == KIND_OPEN) begin
            if (in_word.lock_is_open) begin
                reply = REPLY_ALREADY_OPEN;
            end else begin
                reply        = REPLY_OK;
                phase_next   = PH_DRIVE;
                closing_next = 1'b0;
                elapsed_next = '0;
                poll_next    = 10'd0;
                timer_next   = '0;
            end
        end else if (phase_reg == PH_IDLE && in_word.kind == KIND_CLOSE) begin
            if (!in_word.door_is_closed) begin
                reply = REPLY_DOOR_OPEN;
            end else if (!in_word.lock_is_open) begin
                reply = REPLY_ALREADY_CLOSED;
            end else begin
                reply        = REPLY_OK;
                phase_next   = PH_DRIVE;
                closing_next = 1'b1;
                elapsed_next = '0;
                poll_next    = 10'd0;
                timer_next   = '0;
            end
        end
    end

    // Result word from the updated state
    always_comb begin
        result.reply     = in_word.silent ? REPLY_NONE : reply;
        result.busy_res  = (phase_next != PH_IDLE);
        result.phase_now = phase_next;
        case (phase_next)
            PH_DRIVE, PH_SETTLE: begin
                result.drive_close = closing_next;
                result.drive_open  = ~closing_next;
            end
            PH_REVERSE: begin
                result.drive_open  = closing_next;
                result.drive_close = ~closing_next;
            end
            default: begin
                result.drive_open  = 1'b0;
                result.drive_close = 1'b0;
            end
        endcase
    end

    // State registers, updated once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            closing_reg <= 1'b0;
            elapsed_reg <= '0;
            poll_reg    <= 10'd0;
            timer_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            closing_reg <= closing_next;
            elapsed_reg <= elapsed_next;
            poll_reg    <= poll_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

// ===== src/lock_motor_sequencer.sv =====
// Top level of the lock motor sequencer: config registers, handshake and result register.
//
//  channel | ports                          | word
//  --------+--------------------------------+------------
//  input   | s_valid s_ready s_data         | in_word_t
//  result  | m_valid m_ready m_data         | out_word_t
//  config  | cfg_we cfg_index cfg_wdata     | 12-bit data
//
// Each input word's state update and result are one pass of logic into the result
// register, so one word per cycle is accepted while the result side does not stall.
// A word is taken whenever the result register is empty or is being drained.
// Reset (aresetn low, synchronous) restores the register defaults and idles.
// A stalled result holds m_data; s_ready stays high while it is being taken.
`timescale 1ns / 1ps

module lock_motor_sequencer import lms_pkg::*; #(
    parameter int TIME_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_word_t m_data_reg;
    out_word_t result;
    logic      step;

    assign s_ready = ~m_valid_reg | m_ready;
    assign step    = s_valid & s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_interval      <= RST_POLL_INTERVAL;
            cfg_reg.close_settle_time  <= RST_CLOSE_SETTLE_TIME;
            cfg_reg.open_settle_time   <= RST_OPEN_SETTLE_TIME;
            cfg_reg.drive_timeout      <= RST_DRIVE_TIMEOUT;
            cfg_reg.reverse_pulse_time <= RST_REVERSE_PULSE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_POLL_INTERVAL:     cfg_reg.poll_interval      <= cfg_wdata[9:0];
                CFG_CLOSE_SETTLE_TIME: cfg_reg.close_settle_time  <= cfg_wdata;
                CFG_OPEN_SETTLE_TIME:  cfg_reg.open_settle_time   <= cfg_wdata;
                CFG_DRIVE_TIMEOUT:     cfg_reg.drive_timeout      <= cfg_wdata;
                CFG_REVERSE_PULSE:     cfg_reg.reverse_pulse_time <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lms_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_word (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= result;
        end
    end

endmodule

// ===== bench/lms_checker.sv =====
// Lock motor sequencer checker: tracks the channels, predicts each status word and compares.
`timescale 1ns / 1ps

module lms_checker import lms_pkg::*; #(
    parameter int TIME_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_word_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_word_t              m_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending,
    output logic                   seq_idle
);

    localparam int TIME_MAX = (1 << TIME_BITS) - 1;

    // Mirror of the register file and of the sequencer state
    cfg_t                 timing;
    phase_t               phase_q;
    logic                 closing_q;
    logic [TIME_BITS-1:0] elapsed_ms;
    logic [9:0]           poll_ms;
    logic [TIME_BITS-1:0] dwell_ms;

    out_word_t awaited_status[$];
    int        fails = 0;
    int        seen = 0;

    function automatic int clamp_ms(input int v);
        return (v > TIME_MAX) ? TIME_MAX : v;
    endfunction

    function automatic void enter_reverse();
        dwell_ms = '0;
        phase_q = (clamp_ms(int'(timing.reverse_pulse_time)) == 0) ? PH_IDLE : PH_REVERSE;
    endfunction

    function automatic void enter_settle();
        int settle;
        settle = clamp_ms(int'(closing_q ? timing.close_settle_time
                                         : timing.open_settle_time));
        dwell_ms = '0;
        if (settle == 0)
            enter_reverse();
        else
            phase_q = PH_SETTLE;
    endfunction

    // One millisecond of motor sequencing
    function automatic void tick_ms(input logic lock_open);
        int ivl, tmo, settle;
        ivl = (timing.poll_interval == 0) ? 1 : int'(timing.poll_interval);
        tmo = clamp_ms((timing.drive_timeout == 0) ? 1 : int'(timing.drive_timeout));
        settle = clamp_ms(int'(closing_q ? timing.close_settle_time
                                         : timing.open_settle_time));
        case (phase_q)
            PH_DRIVE: begin
                poll_ms = poll_ms + 10'd1;
                if (poll_ms >= ivl) begin
                    poll_ms = '0;
                    elapsed_ms = TIME_BITS'(clamp_ms(int'(elapsed_ms) + ivl));
                    // sensor at target beats a timeout on the same sample
                    if (closing_q ^ lock_open)
                        enter_settle();
                    else if (elapsed_ms >= tmo)
                        enter_reverse();
                end
            end
            PH_SETTLE: begin
                if (dwell_ms < TIME_MAX)
                    dwell_ms = dwell_ms + TIME_BITS'(1);
                if (dwell_ms >= settle)
                    enter_reverse();
            end
            PH_REVERSE: begin
                if (dwell_ms < TIME_MAX)
                    dwell_ms = dwell_ms + TIME_BITS'(1);
                if (dwell_ms >= clamp_ms(int'(timing.reverse_pulse_time)))
                    phase_q = PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    function automatic void start_drive(input logic to_close);
        phase_q = PH_DRIVE;
        closing_q = to_close;
        elapsed_ms = '0;
        poll_ms = '0;
        dwell_ms = '0;
    endfunction

    // Apply one input word and return the status word it should produce
    function automatic out_word_t next_status(input in_word_t w);
        out_word_t r;
        logic [2:0] rep;
        rep = REPLY_NONE;
        if (w.kind == KIND_TICK) begin
            tick_ms(w.lock_is_open);
        end else if (phase_q == PH_IDLE && w.kind == KIND_OPEN) begin
            if (w.lock_is_open) begin
                rep = REPLY_ALREADY_OPEN;
            end else begin
                rep = REPLY_OK;
                start_drive(1'b0);
            end
        end else if (phase_q == PH_IDLE && w.kind == KIND_CLOSE) begin
            if (!w.door_is_closed) begin
                rep = REPLY_DOOR_OPEN;
            end else if (!w.lock_is_open) begin
                rep = REPLY_ALREADY_CLOSED;
            end else begin
                rep = REPLY_OK;
                start_drive(1'b1);
            end
        end
        if (w.silent)
            rep = REPLY_NONE;

        r = '0;
        if (phase_q == PH_DRIVE || phase_q == PH_SETTLE) begin
            r.drive_close = closing_q;
            r.drive_open  = ~closing_q;
        end else if (phase_q == PH_REVERSE) begin
            r.drive_open  = closing_q;
            r.drive_close = ~closing_q;
        end
        r.reply     = rep;
        r.busy_res  = (phase_q != PH_IDLE);
        r.phase_now = phase_q;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        out_word_t want;
        if (!aresetn) begin
            timing.poll_interval      = RST_POLL_INTERVAL;
            timing.close_settle_time  = RST_CLOSE_SETTLE_TIME;
            timing.open_settle_time   = RST_OPEN_SETTLE_TIME;
            timing.drive_timeout      = RST_DRIVE_TIMEOUT;
            timing.reverse_pulse_time = RST_REVERSE_PULSE;
            phase_q    = PH_IDLE;
            closing_q  = 1'b0;
            elapsed_ms = '0;
            poll_ms    = '0;
            dwell_ms   = '0;
            awaited_status.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POLL_INTERVAL:     timing.poll_interval      = cfg_wdata[9:0];
                    CFG_CLOSE_SETTLE_TIME: timing.close_settle_time  = cfg_wdata;
                    CFG_OPEN_SETTLE_TIME:  timing.open_settle_time   = cfg_wdata;
                    CFG_DRIVE_TIMEOUT:     timing.drive_timeout      = cfg_wdata;
                    CFG_REVERSE_PULSE:     timing.reverse_pulse_time = cfg_wdata;
                    default: ;
                endcase
            end

            // compare the status word leaving the block
            if (m_valid && m_ready) begin
                seen++;
                if (awaited_status.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("status word %0d arrived with none awaited: %b", seen, m_data);
                end else begin
                    want = awaited_status.pop_front();
                    if (m_data.drive_open  !== want.drive_open  ||
                        m_data.drive_close !== want.drive_close ||
                        m_data.reply       !== want.reply       ||
                        m_data.busy_res    !== want.busy_res    ||
                        m_data.phase_now   !== want.phase_now) begin
                        fails++;
                        if (fails <= 10)
                            $display({"status word %0d: expected open=%b close=%b reply=%0d ",
                                      "busy=%b phase=%0d, got open=%b close=%b reply=%0d ",
                                      "busy=%b phase=%0d"},
                                     seen, want.drive_open, want.drive_close, want.reply,
                                     want.busy_res, want.phase_now, m_data.drive_open,
                                     m_data.drive_close, m_data.reply, m_data.busy_res,
                                     m_data.phase_now);
                    end
                end
            end

            // word entering the block
            if (s_valid && s_ready)
                awaited_status.push_back(next_status(s_data));
        end
        fail_count <= fails;
        pending    <= awaited_status.size();
        seq_idle   <= (phase_q == PH_IDLE);
    end

endmodule

// ===== bench/tb_lock_motor_sequencer.sv =====
// Testbench top for the lock motor sequencer: clock, reset, stimulus, result sink and verdict.
`timescale 1ns / 1ps

module tb_lock_motor_sequencer;
    import lms_pkg::*;

    localparam logic [1:0] KIND_BOGUS = 2'd3;   // undefined kind, must be ignored
    localparam int         LONG_HOLD  = 300;
    localparam int         LIMIT      = 2000000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int   fail_count;
    int   pending;
    logic seq_idle;
    int   hold_asks = 0;     // long stalls asked for by the source side
    int   hold_served = 0;   // long stalls done by the sink
    bit   src_calm = 1'b0;
    int   sent = 0;
    int   cycle_no = 0;

    always #1 aclk = ~aclk;

    lock_motor_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lms_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending),
        .seq_idle   (seq_idle)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic in_word_t mk(input logic [1:0] k, input logic s, input logic lk,
                                    input logic dr);
        in_word_t w;
        w.kind           = k;
        w.silent         = s;
        w.lock_is_open   = lk;
        w.door_is_closed = dr;
        return w;
    endfunction

    function automatic in_word_t noise_word();
        return mk(2'($urandom_range(KIND_TICK, KIND_BOGUS)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic cfg_t cfg_of(input int pi, input int cs, input int os, input int dt,
                                    input int rp);
        cfg_t c;
        c.poll_interval      = 10'(pi);
        c.close_settle_time  = 12'(cs);
        c.open_settle_time   = 12'(os);
        c.drive_timeout      = 12'(dt);
        c.reverse_pulse_time = 12'(rp);
        return c;
    endfunction

    // Sender idle cycles: mostly none, a few long
    function automatic int pick_gap();
        int r;
        if (src_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word and wait for the handshake
    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    // Stop offering and wait for every status word to come back
    task automatic wait_quiet();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Ticks until the sequencer is back at rest
    task automatic drain_sequence(input bit pinned, input logic level);
        int n;
        n = 0;
        do begin
            send_word(mk(KIND_TICK, 1'($urandom_range(0, 1)),
                         pinned ? level : 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1))));
            n++;
        end while (!seq_idle && n < 20000);
    endtask

    // Write all five timing registers; junk lands above the 10-bit poll field
    task automatic load_timing(input cfg_t c, input logic [1:0] junk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLL_INTERVAL;
        cfg_wdata <= {junk, c.poll_interval};
        @(posedge aclk);
        cfg_index <= CFG_CLOSE_SETTLE_TIME;
        cfg_wdata <= c.close_settle_time;
        @(posedge aclk);
        cfg_index <= CFG_OPEN_SETTLE_TIME;
        cfg_wdata <= c.open_settle_time;
        @(posedge aclk);
        cfg_index <= CFG_DRIVE_TIMEOUT;
        cfg_wdata <= c.drive_timeout;
        @(posedge aclk);
        cfg_index <= CFG_REVERSE_PULSE;
        cfg_wdata <= c.reverse_pulse_time;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // A command followed by ticks whose lock sensor reaches the target at a random time
    task automatic run_sequence();
        logic to_close, start_lock, door;
        int   ticks, flip_at, i;
        to_close = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 8) begin
            start_lock = to_close;
            door = to_close ? 1'b1 : 1'($urandom_range(0, 1));
        end else begin
            start_lock = 1'($urandom_range(0, 1));
            door = 1'($urandom_range(0, 1));
        end
        send_word(mk(to_close ? KIND_CLOSE : KIND_OPEN, $urandom_range(0, 9) == 0,
                     start_lock, door));
        flip_at = ($urandom_range(0, 4) == 0) ? 100000 : $urandom_range(0, 40);
        ticks = $urandom_range(1, 80);
        for (i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 11) == 0)
                send_word(noise_word());
            else
                send_word(mk(KIND_TICK, 1'($urandom_range(0, 1)),
                             (i >= flip_at) ? ~start_lock : start_lock,
                             1'($urandom_range(0, 1))));
            if (i > 0 && seq_idle && $urandom_range(0, 3) != 0)
                break;
        end
    endtask

    // Result sink: random stalls, long ready stretches, one long hold on request
    initial begin : result_sink
        int n, i;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_asks != hold_served) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_served <= hold_served + 1;
                m_ready     <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
                for (i = 0; i < n && hold_asks == hold_served; i++) @(posedge aclk);
                n = $urandom_range(0, 99);
                n = (n < 60) ? 0 : (n < 90) ? $urandom_range(1, 3) :
                    (n < 98) ? $urandom_range(4, 12) : $urandom_range(20, 60);
                if (n > 0 && hold_asks == hold_served) begin
                    m_ready <= 1'b0;
                    for (i = 0; i < n && hold_asks == hold_served; i++) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        int p, budget, i;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // refusals and ignored words with reset timing
        send_word(mk(KIND_TICK,  1'b0, 1'b0, 1'b0));
        send_word(mk(KIND_BOGUS, 1'b1, 1'b1, 1'b1));
        send_word(mk(KIND_CLOSE, 1'b0, 1'b1, 1'b0));
        send_word(mk(KIND_CLOSE, 1'b0, 1'b0, 1'b1));
        send_word(mk(KIND_OPEN,  1'b0, 1'b1, 1'b1));
        send_word(mk(KIND_CLOSE, 1'b1, 1'b1, 1'b0));
        send_word(mk(KIND_OPEN,  1'b1, 1'b1, 1'b0));
        wait_quiet();

        // all-zero timing: poll and timeout act as one, no settle, no reverse pulse
        load_timing(cfg_of(0, 0, 0, 0, 0), 2'b00);
        send_word(mk(KIND_OPEN,  1'b0, 1'b0, 1'b1));
        send_word(mk(KIND_CLOSE, 1'b0, 1'b1, 1'b1));
        send_word(mk(KIND_OPEN,  1'b1, 1'b1, 1'b0));
        send_word(mk(KIND_TICK,  1'b0, 1'b0, 1'b0));
        send_word(mk(KIND_CLOSE, 1'b1, 1'b1, 1'b1));
        send_word(mk(KIND_TICK,  1'b0, 1'b0, 1'b1));
        wait_quiet();

        // sensor and timeout on the same sample, then a close with settle and pulse
        load_timing(cfg_of(2, 3, 0, 2, 2), 2'b00);
        send_word(mk(KIND_OPEN, 1'b0, 1'b0, 1'b1));
        repeat (4) send_word(mk(KIND_TICK, 1'b0, 1'b1, 1'b0));
        send_word(mk(KIND_CLOSE, 1'b0, 1'b1, 1'b1));
        repeat (7) send_word(mk(KIND_TICK, 1'b1, 1'b0, 1'b1));
        drain_sequence(1'b0, 1'b0);
        wait_quiet();

        // random phases with short timing
        for (p = 0; p < 6; p++) begin
            src_calm = (p == 4);
            load_timing(cfg_of(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4),
                               $urandom_range(0, 8), $urandom_range(0, 8),
                               $urandom_range(0, 24), $urandom_range(0, 6)), 2'b00);
            budget = sent + 30;
            if (p == 2) begin
                // sink holds off while the source keeps pushing
                hold_asks <= hold_asks + 1;
                src_calm = 1'b1;
                send_word(mk(KIND_OPEN, 1'b0, 1'b0, 1'b1));
                for (i = 0; i < 39; i++)
                    send_word(mk(KIND_TICK, 1'b0, i > 20, 1'b0));
                src_calm = 1'b0;
            end
            while (sent < budget)
                run_sequence();
            drain_sequence(1'b0, 1'b0);
            wait_quiet();
        end
        src_calm = 1'b0;

        // mid-range timing
        load_timing(cfg_of(7, 20, 13, 60, 9), 2'b00);
        budget = sent + 40;
        while (sent < budget)
            run_sequence();
        drain_sequence(1'b0, 1'b0);
        wait_quiet();

        // largest values with junk above the poll field: a drive against the widest limits
        load_timing(cfg_of(1023, 4095, 4095, 4095, 4095), 2'b11);
        send_word(mk(KIND_OPEN,  1'b0, 1'b0, 1'b0));
        send_word(mk(KIND_CLOSE, 1'b0, 1'b1, 1'b1));
        send_word(mk(KIND_BOGUS, 1'b0, 1'b0, 1'b0));
        repeat (20) send_word(mk(KIND_TICK, 1'($urandom_range(0, 1)), 1'b0,
                                 1'($urandom_range(0, 1))));
        wait_quiet();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
